[hdl/rlps_pkg.sv]
// shared types and constants of the led pulse serializer
`default_nettype none
package rlps_pkg;

   localparam int CMD_DEPTH = 4;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int RSP_DEPTH = 2;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);

   localparam logic [1:0] CMD_SHOW  = 2'd1;
   localparam logic [1:0] CMD_LATCH = 2'd2;

   localparam logic [1:0] REG_ZERO_HIGH = 2'd0;
   localparam logic [1:0] REG_ONE_HIGH  = 2'd1;
   localparam logic [1:0] REG_PERIOD    = 2'd2;
   localparam logic [1:0] REG_LATCH     = 2'd3;

   localparam logic [4:0] FRAME_BITS = 5'd24;

   typedef struct packed {
      logic [1:0]  command;
      logic [23:0] grb;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } job_slot_type;

   typedef struct packed {
      logic [15:0] zero_high;
      logic [15:0] one_high;
      logic [15:0] period;
      logic [15:0] latch;
   } timing_type;

   typedef struct packed {
      logic data_pin;
      logic busy_res;
      logic rejected;
   } result_type;

endpackage
`default_nettype wire

[hdl/rgb_led_pulse_serializer_top.sv]
// top level of the rgb led pulse serializer with its timing registers
`default_nettype none
// Serial LED data-line driver. Each request is one clock tick of the pin
// waveform and gives exactly one result (pin level, busy, rejected). A show
// request scales red, green and blue by level, then sends green, red, blue
// MSB first; a latch request holds the pin low. Requests are taken one per
// clock while the request queue is not full, and results leave one per clock
// while pop is held. A pushed request is stored in the request queue; the
// sequencer then takes it once the result queue has room and writes its
// result into the result queue at the same edge, from where it can be popped.
// The sequencer does one tick per clock while the result queue has room; a
// four-entry request queue and a two-entry result queue let each side stall
// on its own. Timing registers must be written through the csr port only
// while no request is in flight; the block itself does not enforce this.
module rgb_led_pulse_serializer_top
   import rlps_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output      logic        full,
   input  wire logic [1:0]  req_command,
   input  wire logic [7:0]  req_red,
   input  wire logic [7:0]  req_green,
   input  wire logic [7:0]  req_blue,
   input  wire logic [7:0]  req_level,
   output      logic        empty,
   input  wire logic        pop,
   output      logic        rsp_data_pin,
   output      logic        rsp_busy_res,
   output      logic        rsp_rejected,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   timing_type   timing_ff;
   job_slot_type head;
   logic         take;
   result_type   rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff.zero_high <= 16'd8;
         timing_ff.one_high  <= 16'd15;
         timing_ff.period    <= 16'd30;
         timing_ff.latch     <= 16'd7200;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_ZERO_HIGH: timing_ff.zero_high <= csr_wdata;
            REG_ONE_HIGH:  timing_ff.one_high  <= csr_wdata;
            REG_PERIOD:    timing_ff.period    <= csr_wdata;
            REG_LATCH:     timing_ff.latch     <= csr_wdata;
         endcase
      end
   end

   rlps_front u_front (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .full    (full),
      .command (req_command),
      .red     (req_red),
      .green   (req_green),
      .blue    (req_blue),
      .level   (req_level),
      .head    (head),
      .take    (take)
   );

   rlps_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .take   (take),
      .timing (timing_ff),
      .empty  (empty),
      .pop    (pop),
      .rsp    (rsp)
   );

   assign rsp_data_pin = rsp.data_pin;
   assign rsp_busy_res = rsp.busy_res;
   assign rsp_rejected = rsp.rejected;

`ifndef SYNTHESIS
   // pin only goes high while a frame is running
   a_pin_needs_busy: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_data_pin |-> rsp_busy_res)
      else $error("pin high outside a busy tick");

   // a request is only rejected while a job is running
   a_reject_while_busy: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_rejected |-> rsp_busy_res)
      else $error("request rejected on an idle tick");

   // both queues come out of reset empty
   a_reset_clears: assert property (@(posedge clock)
      reset |=> empty && !full)
      else $error("queues not empty after reset");
`endif

endmodule
`default_nettype wire

[hdl/rlps_front.sv]
// front end: brightness scaling and the request queue toward the sequencer
`default_nettype none
module rlps_front
   import rlps_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   output      logic         full,
   input  wire logic [1:0]   command,
   input  wire logic [7:0]   red,
   input  wire logic [7:0]   green,
   input  wire logic [7:0]   blue,
   input  wire logic [7:0]   level,
   output      job_slot_type head,
   input  wire logic         take
);

   logic [15:0] prod_r;
   logic [15:0] prod_g;
   logic [15:0] prod_b;
   job_type     new_job;

   job_type                mem_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0]   wr_ptr_ff;
   logic [CMD_PTR_W-1:0]   wr_ptr_in;
   logic [CMD_PTR_W-1:0]   rd_ptr_ff;
   logic [CMD_PTR_W-1:0]   rd_ptr_in;
   logic [CMD_PTR_W:0]     count_ff;
   logic [CMD_PTR_W:0]     count_in;
   logic                   do_push;
   logic                   do_pop;

   // (colour * level) >> 8 for each component, packed green, red, blue
   assign prod_r = 16'(red) * 16'(level);
   assign prod_g = 16'(green) * 16'(level);
   assign prod_b = 16'(blue) * 16'(level);

   assign new_job = '{command: command,
                      grb:     {prod_g[15:8], prod_r[15:8], prod_b[15:8]}};

   assign full    = (count_ff == (CMD_PTR_W + 1)'(CMD_DEPTH));
   assign do_push = push && !full;
   assign head    = '{valid: (count_ff != '0), job: mem_ff[rd_ptr_ff]};
   assign do_pop  = take && head.valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= new_job;
      end
   end

endmodule
`default_nettype wire

[hdl/rlps_back.sv]
// back end: bit and latch sequencer, one tick per request, and the result queue
`default_nettype none
module rlps_back
   import rlps_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire job_slot_type head,
   output      logic         take,
   input  wire timing_type   timing,
   output      logic         empty,
   input  wire logic         pop,
   output      result_type   rsp
);

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_SEND  = 2'd1;
   localparam logic [1:0] PH_LATCH = 2'd2;

   logic [23:0] shifter_ff;
   logic [23:0] shifter_in;
   logic [4:0]  bit_index_ff;
   logic [4:0]  bit_index_in;
   logic [15:0] tick_ff;
   logic [15:0] tick_in;
   logic [1:0]  phase_ff;
   logic [1:0]  phase_in;

   logic [23:0] shifter_mid;
   logic [4:0]  bit_index_mid;
   logic [15:0] tick_mid;
   logic [1:0]  phase_mid;
   logic        rejected_mid;
   logic        busy_before;
   logic [15:0] high_ticks;
   logic [16:0] tick_next;
   logic [4:0]  bit_next;
   result_type  res;

   result_type           mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff;
   logic [RSP_PTR_W-1:0] rd_ptr_ff;
   logic [RSP_PTR_W:0]   count_ff;
   logic [RSP_PTR_W:0]   count_in;
   logic                 rsp_full;
   logic                 do_pop;

   assign rsp_full = (count_ff == (RSP_PTR_W + 1)'(RSP_DEPTH));
   assign take     = head.valid && !rsp_full;
   assign empty    = (count_ff == '0);
   assign do_pop   = pop && !empty;
   assign rsp      = mem_ff[rd_ptr_ff];

   assign busy_before = (phase_ff == PH_SEND) || (phase_ff == PH_LATCH);

   // command stage: start a job or flag it when one is running
   always_comb begin
      shifter_mid   = shifter_ff;
      bit_index_mid = bit_index_ff;
      tick_mid      = tick_ff;
      phase_mid     = phase_ff;
      rejected_mid  = 1'b0;
      priority if ((head.job.command == CMD_SHOW || head.job.command == CMD_LATCH)
                   && busy_before) begin
         rejected_mid = 1'b1;
      end else if (head.job.command == CMD_SHOW) begin
         shifter_mid   = head.job.grb;
         bit_index_mid = '0;
         tick_mid      = '0;
         phase_mid     = PH_SEND;
      end else if (head.job.command == CMD_LATCH) begin
         tick_mid  = '0;
         phase_mid = PH_LATCH;
      end else begin
         // plain tick or spare code: nothing to start
         rejected_mid = 1'b0;
      end
   end

   // run stage: one tick of the waveform
   assign high_ticks = shifter_mid[23] ? timing.one_high : timing.zero_high;
   assign tick_next  = {1'b0, tick_mid} + 17'd1;
   assign bit_next   = bit_index_mid + 5'd1;

   always_comb begin
      shifter_in   = shifter_mid;
      bit_index_in = bit_index_mid;
      tick_in      = tick_mid;
      phase_in     = phase_mid;
      res.rejected = rejected_mid;
      res.data_pin = 1'b0;
      res.busy_res = 1'b0;
      unique case (phase_mid)
         PH_SEND: begin
            res.busy_res = 1'b1;
            res.data_pin = (tick_mid < high_ticks);
            if (tick_next >= {1'b0, timing.period}) begin
               tick_in    = '0;
               shifter_in = {shifter_mid[22:0], 1'b0};
               if (bit_next >= FRAME_BITS) begin
                  bit_index_in = '0;
                  phase_in     = PH_IDLE;
               end else begin
                  bit_index_in = bit_next;
               end
            end else begin
               tick_in = tick_next[15:0];
            end
         end
         PH_LATCH: begin
            res.busy_res = 1'b1;
            if (tick_next >= {1'b0, timing.latch}) begin
               tick_in  = '0;
               phase_in = PH_IDLE;
            end else begin
               tick_in = tick_next[15:0];
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_comb begin
      unique case ({take, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shifter_ff   <= '0;
         bit_index_ff <= '0;
         tick_ff      <= '0;
         phase_ff     <= PH_IDLE;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
      end else begin
         if (take) begin
            shifter_ff   <= shifter_in;
            bit_index_ff <= bit_index_in;
            tick_ff      <= tick_in;
            phase_ff     <= phase_in;
            wr_ptr_ff    <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         mem_ff[wr_ptr_ff] <= res;
      end
   end

endmodule
`default_nettype wire
